// File: hdl/sol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sol_pkg
// Shared types and constants of the sequenced overwriting event log.
// ----------------------------------------------------------------------------
package sol_pkg;

  localparam int ENTRY_COUNT_DEF  = 32;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int PAYLOAD_W = 64;
  localparam int SEQ_W     = 32;
  localparam int CNT_W     = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_QUERY,
    CMD_STATUS
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KIND_W-1:0]     kind;
    logic [PAYLOAD_W-1:0]  payload;
    logic [SEQ_W-1:0]      last_seq;
    logic [CNT_W-1:0]      limit;
  } cmd_entry_t;

endpackage : sol_pkg
`default_nettype wire

// File: hdl/sol_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sol_front
// Command intake: decodes the op code, resolves the query limit and issues
// the command to the queue.
// ----------------------------------------------------------------------------
module sol_front #(
  parameter int ENTRY_COUNT = sol_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sol_pkg::OP_W-1:0]       in_op,
  input  wire logic [sol_pkg::KIND_W-1:0]     in_event_kind,
  input  wire logic [sol_pkg::PAYLOAD_W-1:0]  in_event_payload,
  input  wire logic [sol_pkg::SEQ_W-1:0]      in_last_sequence,
  input  wire logic [sol_pkg::CNT_W-1:0]      in_max_entries,
  input  wire logic                           q_full,
  output logic                                q_push,
  output sol_pkg::cmd_entry_t                 q_entry
);

  always_comb begin
    busy   = q_full;
    q_push = start && !q_full;

    q_entry.kind     = in_event_kind;
    q_entry.payload  = in_event_payload;
    q_entry.last_seq = in_last_sequence;
    q_entry.limit    = (in_max_entries == '0) ? sol_pkg::CNT_W'(ENTRY_COUNT)
                                              : in_max_entries;
    case (in_op)
      sol_pkg::OP_PUSH:  q_entry.cmd = sol_pkg::CMD_PUSH;
      sol_pkg::OP_QUERY: q_entry.cmd = sol_pkg::CMD_QUERY;
      default:           q_entry.cmd = sol_pkg::CMD_STATUS;
    endcase
  end

endmodule : sol_front
`default_nettype wire

// File: hdl/sol_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sol_queue
// Short command queue between intake and execution.
// ----------------------------------------------------------------------------
module sol_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire sol_pkg::cmd_entry_t   push_entry,
  output logic                       full,
  output logic                       not_empty,
  input  wire logic                  pop,
  output sol_pkg::cmd_entry_t        head_entry
);

  localparam int DEPTH = sol_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  sol_pkg::cmd_entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    not_empty  = (count_r != '0);
    head_entry = slot_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && not_empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule : sol_queue
`default_nettype wire

// File: hdl/sol_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sol_back
// Execution: ring storage, push bookkeeping and the oldest-first query scan
// with one entry held back so that the final result can be flagged.
// ----------------------------------------------------------------------------
module sol_back #(
  parameter int ENTRY_COUNT  = sol_pkg::ENTRY_COUNT_DEF,
  parameter int PAYLOAD_BITS = sol_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_not_empty,
  input  wire sol_pkg::cmd_entry_t            q_entry,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [sol_pkg::SEQ_W-1:0]           out_oldest_sequence,
  output logic [sol_pkg::SEQ_W-1:0]           out_current_sequence,
  output logic                                out_overflowed,
  output logic                                out_has_entry,
  output logic [sol_pkg::SEQ_W-1:0]           out_entry_sequence,
  output logic [sol_pkg::KIND_W-1:0]          out_entry_kind,
  output logic [sol_pkg::PAYLOAD_W-1:0]       out_entry_payload,
  output logic [sol_pkg::CNT_W-1:0]           out_returned_count,
  output logic                                out_last
);

  localparam int SEQ_W  = sol_pkg::SEQ_W;
  localparam int KIND_W = sol_pkg::KIND_W;
  localparam int CNT_W  = sol_pkg::CNT_W;
  localparam int IDX_W  = $clog2(ENTRY_COUNT);
  localparam int FILL_W = $clog2(ENTRY_COUNT + 1);
  localparam int ENT_W  = SEQ_W + KIND_W + PAYLOAD_BITS;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRY_COUNT - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(ENTRY_COUNT);

  logic [ENT_W-1:0] mem [ENTRY_COUNT];
  logic [ENT_W-1:0] rd_q;
  logic             mem_we, mem_re;

  sol_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [IDX_W-1:0]  scan_ptr_r, scan_ptr_nxt;
  logic [FILL_W-1:0] remain_r, remain_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              first_r, first_nxt;
  logic              is_query_r, is_query_nxt;
  logic [SEQ_W-1:0]  last_seq_r, last_seq_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic [SEQ_W-1:0]  oldest_r, oldest_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic              pend_fin_r, pend_fin_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [SEQ_W-1:0]  pend_seq_r, pend_seq_nxt;
  logic [KIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic [PAYLOAD_BITS-1:0] pend_pay_r, pend_pay_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SEQ_W-1:0]  out_oldest_r, out_oldest_nxt;
  logic [SEQ_W-1:0]  out_current_r, out_current_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_has_r, out_has_nxt;
  logic [SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;

  logic [SEQ_W-1:0]        rd_seq;
  logic [KIND_W-1:0]       rd_kind;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [SEQ_W-1:0]        current_seq;
  logic [SEQ_W-1:0]        cursor_next;
  logic                    ovf;
  logic                    match;
  logic [CNT_W-1:0]        cnt_inc;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_seq      = rd_q[ENT_W-1 -: SEQ_W];
    rd_kind     = rd_q[PAYLOAD_BITS +: KIND_W];
    rd_pay      = rd_q[PAYLOAD_BITS-1:0];
    current_seq = (next_seq_r == '0) ? '0 : next_seq_r - 1'b1;
    cursor_next = last_seq_r + 1'b1;
    ovf         = (last_seq_r != '0) && (oldest_r != '0) && (cursor_next < oldest_r);
    match       = rd_vld_r && is_query_r && !pend_fin_r && (rd_seq > last_seq_r);
    cnt_inc     = pend_cnt_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    next_seq_nxt  = next_seq_r;
    scan_ptr_nxt  = scan_ptr_r;
    remain_nxt    = remain_r;
    first_nxt     = first_r;
    is_query_nxt  = is_query_r;
    last_seq_nxt  = last_seq_r;
    limit_nxt     = limit_r;
    oldest_nxt    = oldest_r;
    pend_vld_nxt  = pend_vld_r;
    pend_fin_nxt  = pend_fin_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_seq_nxt  = pend_seq_r;
    pend_kind_nxt = pend_kind_r;
    pend_pay_nxt  = pend_pay_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    out_valid_nxt   = 1'b0;
    out_oldest_nxt  = out_oldest_r;
    out_current_nxt = out_current_r;
    out_ovf_nxt     = out_ovf_r;
    out_has_nxt     = out_has_r;
    out_seq_nxt     = out_seq_r;
    out_kind_nxt    = out_kind_r;
    out_pay_nxt     = out_pay_r;
    out_cnt_nxt     = out_cnt_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      sol_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_entry.cmd == sol_pkg::CMD_PUSH) begin
            mem_we       = 1'b1;
            tail_nxt     = ptr_inc(tail_r);
            next_seq_nxt = next_seq_r + 1'b1;
            if (fill_r == FULL) begin
              head_nxt = ptr_inc(head_r);
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            state_nxt    = sol_pkg::ST_SCAN;
            is_query_nxt = (q_entry.cmd == sol_pkg::CMD_QUERY);
            last_seq_nxt = q_entry.last_seq;
            limit_nxt    = q_entry.limit;
            scan_ptr_nxt = head_r;
            remain_nxt   = (q_entry.cmd == sol_pkg::CMD_QUERY) ? fill_r
                                                              : FILL_W'(fill_r != '0);
            oldest_nxt   = '0;
            first_nxt    = 1'b1;
            pend_vld_nxt = 1'b0;
            pend_fin_nxt = 1'b0;
            pend_cnt_nxt = '0;
          end
        end
      end
      sol_pkg::ST_SCAN: begin
        if (remain_r != '0 && !pend_fin_r) begin
          mem_re       = 1'b1;
          scan_ptr_nxt = ptr_inc(scan_ptr_r);
          remain_nxt   = remain_r - 1'b1;
        end
        if (rd_vld_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            oldest_nxt = rd_seq;
          end
        end
        if (pend_vld_r && pend_fin_r) begin
          out_valid_nxt   = 1'b1;
          out_has_nxt     = 1'b1;
          out_last_nxt    = 1'b1;
          state_nxt       = sol_pkg::ST_IDLE;
        end else if (match) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_has_nxt   = 1'b1;
            out_last_nxt  = 1'b0;
          end
          pend_vld_nxt  = 1'b1;
          pend_cnt_nxt  = cnt_inc;
          pend_fin_nxt  = (cnt_inc == limit_r);
          pend_seq_nxt  = rd_seq;
          pend_kind_nxt = rd_kind;
          pend_pay_nxt  = rd_pay;
        end else if (remain_r == '0 && !rd_vld_r) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = pend_vld_r;
          out_last_nxt  = 1'b1;
          state_nxt     = sol_pkg::ST_IDLE;
        end
        if (out_valid_nxt) begin
          out_oldest_nxt  = oldest_r;
          out_current_nxt = current_seq;
          out_ovf_nxt     = ovf;
          out_seq_nxt     = out_has_nxt ? pend_seq_r  : '0;
          out_kind_nxt    = out_has_nxt ? pend_kind_r : '0;
          out_pay_nxt     = out_has_nxt ? pend_pay_r  : '0;
          out_cnt_nxt     = out_has_nxt ? pend_cnt_r  : '0;
        end
      end
      default: begin
        state_nxt = sol_pkg::ST_IDLE;
      end
    endcase

    rd_vld_nxt = mem_re;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sol_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      next_seq_r  <= SEQ_W'(1);
      remain_r    <= '0;
      rd_vld_r    <= 1'b0;
      first_r     <= 1'b0;
      is_query_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      pend_fin_r  <= 1'b0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      next_seq_r  <= next_seq_nxt;
      remain_r    <= remain_nxt;
      rd_vld_r    <= rd_vld_nxt;
      first_r     <= first_nxt;
      is_query_r  <= is_query_nxt;
      pend_vld_r  <= pend_vld_nxt;
      pend_fin_r  <= pend_fin_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r    <= scan_ptr_nxt;
    last_seq_r    <= last_seq_nxt;
    limit_r       <= limit_nxt;
    oldest_r      <= oldest_nxt;
    pend_seq_r    <= pend_seq_nxt;
    pend_kind_r   <= pend_kind_nxt;
    pend_pay_r    <= pend_pay_nxt;
    out_oldest_r  <= out_oldest_nxt;
    out_current_r <= out_current_nxt;
    out_ovf_r     <= out_ovf_nxt;
    out_has_r     <= out_has_nxt;
    out_seq_r     <= out_seq_nxt;
    out_kind_r    <= out_kind_nxt;
    out_pay_r     <= out_pay_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= {next_seq_r, q_entry.kind, q_entry.payload[PAYLOAD_BITS-1:0]};
    end
    if (mem_re) begin
      rd_q <= mem[scan_ptr_r];
    end
  end

  always_comb begin
    out_valid            = out_valid_r;
    out_oldest_sequence  = out_oldest_r;
    out_current_sequence = out_current_r;
    out_overflowed       = out_ovf_r;
    out_has_entry        = out_has_r;
    out_entry_sequence   = out_seq_r;
    out_entry_kind       = out_kind_r;
    out_entry_payload    = sol_pkg::PAYLOAD_W'(out_pay_r);
    out_returned_count   = out_cnt_r;
    out_last             = out_last_r;
  end

endmodule : sol_back
`default_nettype wire

// File: hdl/sequenced_overwriting_event_log.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sequenced_overwriting_event_log
// Ring journal of sequence-stamped events with cursor-based readout.
// ----------------------------------------------------------------------------
// Commands enter on start while busy is low and wait in a two-deep queue;
// busy is high only while that queue is full. A push is popped and written
// to storage by the back end in the same cycle, so pushes sustain one per
// cycle while no query or status command holds the back end. A query holds
// the back end while it dispatches, makes one registered storage read per
// stored entry walked oldest first, waits for the read of the last entry
// and closes; on an empty journal it only dispatches and closes, and a query
// that reaches its limit stops the walk early. A status command reads only
// the oldest entry. Results appear on out_valid for exactly one cycle each
// and cannot be held off; entries that do not match are skipped silently,
// so the results of one query may be separated by idle cycles. out_last
// marks the final result of every query and status command.
module sequenced_overwriting_event_log #(
  parameter int ENTRY_COUNT  = sol_pkg::ENTRY_COUNT_DEF,
  parameter int PAYLOAD_BITS = sol_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sol_pkg::OP_W-1:0]       in_op,
  input  wire logic [sol_pkg::KIND_W-1:0]     in_event_kind,
  input  wire logic [sol_pkg::PAYLOAD_W-1:0]  in_event_payload,
  input  wire logic [sol_pkg::SEQ_W-1:0]      in_last_sequence,
  input  wire logic [sol_pkg::CNT_W-1:0]      in_max_entries,
  output logic                                out_valid,
  output logic [sol_pkg::SEQ_W-1:0]           out_oldest_sequence,
  output logic [sol_pkg::SEQ_W-1:0]           out_current_sequence,
  output logic                                out_overflowed,
  output logic                                out_has_entry,
  output logic [sol_pkg::SEQ_W-1:0]           out_entry_sequence,
  output logic [sol_pkg::KIND_W-1:0]          out_entry_kind,
  output logic [sol_pkg::PAYLOAD_W-1:0]       out_entry_payload,
  output logic [sol_pkg::CNT_W-1:0]           out_returned_count,
  output logic                                out_last
);

  logic                q_push;
  logic                q_full;
  logic                q_not_empty;
  logic                q_pop;
  sol_pkg::cmd_entry_t q_in_entry;
  sol_pkg::cmd_entry_t q_head_entry;

  sol_front #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_front (
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_event_kind    (in_event_kind),
    .in_event_payload (in_event_payload),
    .in_last_sequence (in_last_sequence),
    .in_max_entries   (in_max_entries),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in_entry)
  );

  sol_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .head_entry (q_head_entry)
  );

  sol_back #(
    .ENTRY_COUNT  (ENTRY_COUNT),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_entry              (q_head_entry),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_oldest_sequence  (out_oldest_sequence),
    .out_current_sequence (out_current_sequence),
    .out_overflowed       (out_overflowed),
    .out_has_entry        (out_has_entry),
    .out_entry_sequence   (out_entry_sequence),
    .out_entry_kind       (out_entry_kind),
    .out_entry_payload    (out_entry_payload),
    .out_returned_count   (out_returned_count),
    .out_last             (out_last)
  );

  a_header_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_entry |-> out_last)
    else $error("header-only result without final flag");

  a_entry_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_entry |-> out_returned_count != '0)
    else $error("entry result with zero count");

  a_gap_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after final result");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule : sequenced_overwriting_event_log
`default_nettype wire
